/* design/mcd_pkg.sv */
// Shared types and constants for the motion continuity detector.
// No dependencies; imported by every module of the block but the checker.
`timescale 1ns / 1ps
`default_nettype none
package mcd_pkg;

	localparam int SENSOR_COUNT_DEF = 8;
	localparam int ID_W             = 3;
	localparam int TIME_W           = 32;
	localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd30000;

	// One channel's stored state; a time of zero means unset.
	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] idle_start;
		logic [TIME_W-1:0] idle_end;
		logic [TIME_W-1:0] active_start;
	} chan_state_t;

	typedef struct packed {
		logic        hit;
		chan_state_t next;
	} upd_res_t;

endpackage
`default_nettype wire

/* design/motion_continuity_detector.sv */
// A result is registered into the output register when its beat leaves the
// stage-1 register. Throughput: one beat per cycle unless the output stalls;
// each beat reads its channel from the state memory and writes it back as it
// leaves stage 1; a forward register covers a read that lands on the same
// edge as the write of the same channel. Reset: all channels read as zero at
// once (per-entry written bits), timeout returns to 30000 ms; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module motion_continuity_detector #(
	parameter int SENSOR_COUNT = mcd_pkg::SENSOR_COUNT_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire  [mcd_pkg::TIME_W-1:0]  cfg_wr_data,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  [mcd_pkg::ID_W-1:0]    sensor_id,
	input  wire                         fired,
	input  wire  [mcd_pkg::TIME_W-1:0]  now_ms,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic                        continue_active
);
	import mcd_pkg::*;

	localparam int ADDR_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

	logic [TIME_W-1:0]   timeout_q;
	logic [ADDR_W+ID_W-1:0] id_wide;
	logic [ADDR_W-1:0]   addr_in;
	logic                id_ok_in;
	logic                accept;
	logic                adv;

	logic                vld_s1;
	logic                id_ok_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                fired_s1;
	logic [TIME_W-1:0]   now_s1;

	logic                fwd_vld_q;
	logic [ADDR_W-1:0]   fwd_addr_q;
	chan_state_t         fwd_data_q;

	chan_state_t         rd_data;
	chan_state_t         cur;
	upd_res_t            upd;

	logic                out_valid_q;
	logic                cont_q;

	assign id_wide  = (ADDR_W+ID_W)'(sensor_id);
	assign addr_in  = id_wide[ADDR_W-1:0];
	assign id_ok_in = (32'(sensor_id) < 32'(SENSOR_COUNT));

	assign adv      = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready = !vld_s1 || adv;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	mcd_state_ram #(
		.DEPTH  (SENSOR_COUNT),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (addr_in),
		.rd_data (rd_data),
		.wr_en   (adv && id_ok_s1),
		.wr_addr (addr_s1),
		.wr_data (upd.next)
	);

	// the last write always matches memory, so a hit on it is always safe
	assign cur = (fwd_vld_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data;

	mcd_update u_upd (
		.cur     (cur),
		.fired   (fired_s1),
		.now_ms  (now_s1),
		.timeout (timeout_q),
		.res     (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			fwd_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv && id_ok_s1) begin
				fwd_vld_q <= 1'b1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_ok_s1 <= id_ok_in;
			addr_s1  <= addr_in;
			fired_s1 <= fired;
			now_s1   <= now_ms;
		end
		if (adv && id_ok_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= upd.next;
		end
		if (adv) begin
			cont_q <= id_ok_s1 && upd.hit;
		end
	end

	assign out_valid       = out_valid_q;
	assign continue_active = cont_q;

endmodule
`default_nettype wire

/* design/mcd_state_ram.sv */
// Per-channel state memory: one write and one registered read per cycle.
// Entries never written since reset read as zero. Depends on mcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mcd_state_ram #(
	parameter int DEPTH  = mcd_pkg::SENSOR_COUNT_DEF,
	parameter int ADDR_W = 3
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       rd_en,
	input  wire  [ADDR_W-1:0]         rd_addr,
	output mcd_pkg::chan_state_t      rd_data,
	input  wire                       wr_en,
	input  wire  [ADDR_W-1:0]         wr_addr,
	input  wire mcd_pkg::chan_state_t wr_data
);
	import mcd_pkg::*;

	chan_state_t    mem [DEPTH];
	logic [DEPTH-1:0] written_q;
	chan_state_t    rd_word_q;
	logic           rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_word_q : '0;

endmodule
`default_nettype wire

/* design/mcd_update.sv */
// Next-state and hit logic for one channel sample.
// Depends on mcd_pkg for the channel state types.
`timescale 1ns / 1ps
`default_nettype none
module mcd_update (
	input  wire mcd_pkg::chan_state_t   cur,
	input  wire                         fired,
	input  wire  [mcd_pkg::TIME_W-1:0]  now_ms,
	input  wire  [mcd_pkg::TIME_W-1:0]  timeout,
	output mcd_pkg::upd_res_t           res
);
	import mcd_pkg::*;

	chan_state_t       st;
	logic [TIME_W-1:0] idle_gap;
	logic [TIME_W-1:0] active_age;
	logic              hit;

	always_comb begin
		st = cur;
		if (cur.level != fired) begin
			st.level = fired;
			if (fired) begin
				st.idle_end     = now_ms;
				st.active_start = now_ms;
			end else begin
				st.idle_start   = now_ms;
				st.idle_end     = '0;
				st.active_start = '0;
			end
		end
		idle_gap   = st.idle_end - st.idle_start;
		active_age = now_ms - st.active_start;
		hit = ((st.idle_end != '0) && (idle_gap < timeout)) ||
		      ((st.active_start != '0) && (active_age > timeout));
		res.hit  = hit;
		res.next = st;
		// drop all three times once activity is reported
		if (hit) begin
			res.next.idle_start   = '0;
			res.next.idle_end     = '0;
			res.next.active_start = '0;
		end
	end

endmodule
`default_nettype wire

/* design/mcd_checker.sv */
// Port-level checks for motion_continuity_detector, bound to the top level.
// No package dependency; sees the top-level ports only.
`timescale 1ns / 1ps
`default_nettype none
module mcd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire        continue_active
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(continue_active))
		else $error("result beat changed while stalled");

	// input backpressure only comes from a stalled output
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a result taken frees room for a new beat in the same cycle
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input not ready while result drains");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input not ready with empty output");

endmodule

bind motion_continuity_detector mcd_checker u_mcd_checker (.*);
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for motion_continuity_detector.
// Drives sensor samples over a valid/ready channel and checks each continuity
// flag against an in-bench channel model; depends on mcd_pkg and the block RTL.
`timescale 1ns / 1ps
module tb;
	import mcd_pkg::*;

	localparam int CHANNELS    = SENSOR_COUNT_DEF;
	localparam int STALL_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 255;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wr_en   = 1'b0;
	logic [TIME_W-1:0] cfg_wr_data = '0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [ID_W-1:0]   sensor_id   = '0;
	logic              fired       = 1'b0;
	logic [TIME_W-1:0] now_ms      = '0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              continue_active;

	// Channel model and expected flags
	chan_state_t       chan_q [CHANNELS];
	logic [TIME_W-1:0] timeout_ms;
	logic              pending_hits [$];
	logic [TIME_W-1:0] clock_ms;
	int                mismatch_cnt  = 0;
	int                hold_off_left = 0;
	bit                no_idle       = 1'b0;

	motion_continuity_detector i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sensor_id       (sensor_id),
		.fired           (fired),
		.now_ms          (now_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.continue_active (continue_active)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic predict_continuity(input logic [ID_W-1:0] id, input logic lvl,
			input logic [TIME_W-1:0] t);
		chan_state_t       s;
		logic              hit;
		logic [TIME_W-1:0] refire_gap;
		logic [TIME_W-1:0] active_run;
		s = chan_q[id];
		if (s.level != lvl) begin
			s.level = lvl;
			if (lvl) begin
				s.idle_end     = t;
				s.active_start = t;
			end else begin
				s.idle_start   = t;
				s.idle_end     = '0;
				s.active_start = '0;
			end
		end
		refire_gap = s.idle_end - s.idle_start;
		active_run = t - s.active_start;
		hit = (s.idle_end != '0 && refire_gap < timeout_ms) ||
			(s.active_start != '0 && active_run > timeout_ms);
		if (hit) begin
			s.idle_start   = '0;
			s.idle_end     = '0;
			s.active_start = '0;
		end
		chan_q[id] = s;
		return hit;
	endfunction

	// Call just after a rising edge; returns at the edge that takes the beat.
	task automatic send_sample(input logic [ID_W-1:0] id, input logic lvl,
			input logic [TIME_W-1:0] t);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		sensor_id <= id;
		fired     <= lvl;
		now_ms    <= t;
		do @(posedge clk); while (!in_ready);
		pending_hits.push_back(predict_continuity(id, lvl, t));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_timeout(input logic [TIME_W-1:0] value);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		timeout_ms = value;
		cfg_wr_en <= 1'b0;
	endtask

	// Receiver: random stall per beat, plus an optional long hold-off
	initial begin
		int  stall_left;
		logic want;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_hits.size() == 0) begin
					$display("%0t unexpected beat: expected none, actual continue_active=%0b",
						$time, continue_active);
					mismatch_cnt++;
				end else begin
					want = pending_hits.pop_front();
					if (continue_active !== want) begin
						$display("%0t continue_active mismatch: expected %0b, actual %0b",
							$time, want, continue_active);
						mismatch_cnt++;
					end
				end
				stall_left = no_idle ? 0 : $urandom_range(0, 10);
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles without any accepted beat
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
				$display("[motion_continuity_detector] ERROR");
				$finish;
			end
		end
	end

	task automatic test_reset_timeout();
		// first fire of a channel, time zero, exact boundaries, wrap of time
		send_sample(3'd0, 1'b1, 32'd5000);
		send_sample(3'd0, 1'b1, 32'd6000);
		send_sample(3'd0, 1'b0, 32'd7000);
		send_sample(3'd0, 1'b1, 32'd20000);
		send_sample(3'd1, 1'b1, 32'd0);
		send_sample(3'd1, 1'b1, 32'd30000);
		send_sample(3'd1, 1'b0, 32'd40000);
		send_sample(3'd1, 1'b1, 32'd70000);
		send_sample(3'd1, 1'b1, 32'd100000);
		send_sample(3'd1, 1'b1, 32'd100001);
		send_sample(3'd2, 1'b1, 32'hFFFF_FFFF);
		send_sample(3'd2, 1'b1, 32'h0000_7530);
		send_sample(3'd3, 1'b1, 32'd40000);
		send_sample(3'd3, 1'b0, 32'hFFFF_F000);
		send_sample(3'd3, 1'b1, 32'h0000_0100);
		send_sample(3'd4, 1'b0, 32'd123);
		send_sample(3'd5, 1'b0, 32'd0);
		send_sample(3'd5, 1'b1, 32'hAAAA_5555);
		send_sample(3'd6, 1'b1, 32'd31000);
		send_sample(3'd6, 1'b0, 32'd32000);
		send_sample(3'd7, 1'b1, 32'd1);
	endtask

	task automatic test_timeout_extremes();
		set_timeout('0);
		send_sample(3'd4, 1'b1, 32'd10);
		send_sample(3'd4, 1'b1, 32'd11);
		send_sample(3'd4, 1'b0, 32'd12);
		send_sample(3'd4, 1'b1, 32'd12);
		set_timeout('1);
		send_sample(3'd6, 1'b1, 32'd4);
		send_sample(3'd6, 1'b1, 32'd3);
		send_sample(3'd7, 1'b0, 32'h5555_AAAA);
		send_sample(3'd7, 1'b1, 32'h5555_AAA9);
	endtask

	task automatic send_random_sample();
		logic [ID_W-1:0]   id;
		logic              lvl;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] span;
		id  = ID_W'($urandom_range(0, CHANNELS - 1));
		lvl = ($urandom_range(0, 9) < 7) ? ~chan_q[id].level : chan_q[id].level;
		if (timeout_ms == '0)
			span = 32'd16;
		else if (timeout_ms > 32'h7FFF_FFFF)
			span = '1;
		else
			span = timeout_ms << 1;
		case ($urandom_range(0, 9))
			6: t = chan_q[id].active_start + timeout_ms + $urandom_range(0, 2) - 1;
			7: begin
				lvl = 1'b1;
				t = chan_q[id].idle_start + timeout_ms + $urandom_range(0, 2) - 1;
			end
			8: t = $urandom;
			9: t = '0;
			default: begin
				clock_ms = clock_ms + $urandom_range(0, span);
				t = clock_ms;
			end
		endcase
		send_sample(id, lvl, t);
	endtask

	task automatic test_random_phases();
		logic [TIME_W-1:0] phase_timeout [7];
		phase_timeout = '{32'd30000, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd1000, 32'd0,
			32'h8000_0000};
		phase_timeout[5] = $urandom;
		for (int p = 0; p < 7; p++) begin
			set_timeout(phase_timeout[p]);
			clock_ms = $urandom;
			// run one phase back to back on both sides
			no_idle = (p == 4);
			repeat (PHASE_ITEMS) send_random_sample();
			no_idle = 1'b0;
		end
	endtask

	task automatic test_output_backpressure();
		set_timeout(32'd500);
		hold_off_left = HOLD_CYCLES;
		no_idle = 1'b1;
		repeat (40) send_random_sample();
		no_idle = 1'b0;
	endtask

	initial begin
		timeout_ms = TIMEOUT_RST;
		clock_ms   = '0;
		for (int k = 0; k < CHANNELS; k++)
			chan_q[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_timeout();
		test_timeout_extremes();
		test_output_backpressure();
		test_random_phases();
		drain_results();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0 && pending_hits.size() == 0)
			$display("[motion_continuity_detector] OK");
		else
			$display("[motion_continuity_detector] ERROR");
		$finish;
	end

endmodule

/* files.f */
design/mcd_pkg.sv
design/mcd_state_ram.sv
design/mcd_update.sv
design/motion_continuity_detector.sv
design/mcd_checker.sv
verif/tb.sv
